@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every module that uses them has clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/jsu_pkg.sv @@
package jsu_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned AddrW     = $clog2(FifoDepth);
  localparam int unsigned CntW      = AddrW + 1;

  typedef enum logic [2:0] {
    PH_QUOTE    = 3'd0,
    PH_STRING   = 3'd1,
    PH_ESCAPE   = 3'd2,
    PH_HEX      = 3'd3,
    PH_FINISHED = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerB = 8'h62;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChLowerU = 8'h75;

  // One front-end command: up to three data bytes, then an optional status.
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic            has_tail;
    status_e         tail_status;
  } cmd_t;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {valid, byte} for the single-character escapes
  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      ChQuote:  r = {1'b1, ChQuote};
      ChBslash: r = {1'b1, ChBslash};
      ChSlash:  r = {1'b1, ChSlash};
      ChLowerN: r = {1'b1, 8'h0A};
      ChLowerT: r = {1'b1, 8'h09};
      ChLowerR: r = {1'b1, 8'h0D};
      ChLowerB: r = {1'b1, 8'h08};
      ChLowerF: r = {1'b1, 8'h0C};
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/jsu_cmd_fifo.sv @@
`include "assert_macros.svh"

module jsu_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  jsu_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          rd_valid_o,
  output jsu_pkg::cmd_t rd_data_o
);
  import jsu_pkg::*;

  cmd_t             entries_q [FifoDepth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = entries_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + AddrW'(1);
      if (rd_i) rd_ptr_q <= rd_ptr_q + AddrW'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(FifoDepth), "command queue count out of range")
  `ASSERT_IMPLIES(a_no_overflow, wr_i && !rd_i, !full_o, "write into full command queue")
  `ASSERT_IMPLIES(a_no_underflow, rd_i, rd_valid_o, "read from empty command queue")

endmodule

@@ rtl/core/jsu_front.sv @@
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    data_byte_i,
  input  logic          start_of_text_i,
  input  logic          end_of_text_i,
  output logic          cmd_push_o,
  output jsu_pkg::cmd_t cmd_o
);
  import jsu_pkg::*;

  phase_e      phase_q, ph_cur, ph_step, ph_end;
  logic [11:0] acc_q, acc_d, acc_cur;
  logic [1:0]  cnt_q, cnt_d, cnt_cur;
  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [15:0] code;
  cmd_t        cmd;

  assign hex  = hex_decode(data_byte_i);
  assign esc  = esc_decode(data_byte_i);
  assign code = {acc_cur, hex[3:0]};

  // Next-state logic
  always_comb begin
    ph_cur  = start_of_text_i ? PH_QUOTE : phase_q;
    acc_cur = start_of_text_i ? '0 : acc_q;
    cnt_cur = start_of_text_i ? '0 : cnt_q;
    ph_step = ph_cur;
    acc_d   = acc_cur;
    cnt_d   = cnt_cur;
    case (ph_cur)
      PH_QUOTE: begin
        ph_step = (data_byte_i == ChQuote) ? PH_STRING : PH_FINISHED;
      end
      PH_STRING: begin
        if (data_byte_i == ChQuote) begin
          ph_step = PH_FINISHED;
        end else if (data_byte_i == ChBslash) begin
          ph_step = PH_ESCAPE;
        end
      end
      PH_ESCAPE: begin
        if (data_byte_i == ChLowerU) begin
          ph_step = PH_HEX;
          acc_d   = '0;
          cnt_d   = '0;
        end else begin
          ph_step = esc[8] ? PH_STRING : PH_FINISHED;
        end
      end
      PH_HEX: begin
        if (!hex[4]) begin
          ph_step = PH_FINISHED;
        end else if (cnt_cur == 2'd3) begin
          ph_step = PH_STRING;
          cnt_d   = '0;
        end else begin
          acc_d = {acc_cur[7:0], hex[3:0]};
          cnt_d = cnt_cur + 2'd1;
        end
      end
      default: ph_step = PH_FINISHED;
    endcase
    ph_end = (end_of_text_i && ph_step != PH_FINISHED) ? PH_FINISHED : ph_step;
  end

  // Command build
  always_comb begin
    cmd             = '0;
    cmd.tail_status = ST_ERROR;
    case (ph_cur)
      PH_QUOTE: begin
        cmd.has_tail = (data_byte_i != ChQuote);
      end
      PH_STRING: begin
        if (data_byte_i == ChQuote) begin
          cmd.has_tail    = 1'b1;
          cmd.tail_status = ST_DONE;
        end else if (data_byte_i != ChBslash) begin
          cmd.nbytes   = 2'd1;
          cmd.bytes[0] = data_byte_i;
        end
      end
      PH_ESCAPE: begin
        if (data_byte_i != ChLowerU) begin
          if (esc[8]) begin
            cmd.nbytes   = 2'd1;
            cmd.bytes[0] = esc[7:0];
          end else begin
            cmd.has_tail = 1'b1;
          end
        end
      end
      PH_HEX: begin
        if (!hex[4]) begin
          cmd.has_tail = 1'b1;
        end else if (cnt_cur == 2'd3) begin
          if (code < 16'h0080) begin
            cmd.nbytes   = 2'd1;
            cmd.bytes[0] = code[7:0];
          end else if (code < 16'h0800) begin
            cmd.nbytes   = 2'd2;
            cmd.bytes[0] = 8'hC0 | {3'b000, code[10:6]};
            cmd.bytes[1] = 8'h80 | {2'b00, code[5:0]};
          end else begin
            cmd.nbytes   = 2'd3;
            cmd.bytes[0] = 8'hE0 | {4'h0, code[15:12]};
            cmd.bytes[1] = 8'h80 | {2'b00, code[11:6]};
            cmd.bytes[2] = 8'h80 | {2'b00, code[5:0]};
          end
        end
      end
      default: ;
    endcase
    // text ran out with the string still open
    if (end_of_text_i && ph_step != PH_FINISHED) begin
      cmd.has_tail    = 1'b1;
      cmd.tail_status = ST_ERROR;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = fire_i && (cmd.nbytes != 2'd0 || cmd.has_tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_QUOTE;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= ph_end;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/core/jsu_emit.sv @@
`include "assert_macros.svh"

module jsu_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  jsu_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       out_byte_o,
  output jsu_pkg::status_e status_o,
  output logic             last_o
);
  import jsu_pkg::*;

  logic       ov_q;
  logic [1:0] idx_q;
  logic [7:0] byte_q, byte_d;
  status_e    status_q, status_d;
  logic       last_q;
  logic [2:0] total;
  logic       is_last, load;

  assign total   = {1'b0, cmd_i.nbytes} + {2'b00, cmd_i.has_tail};
  assign is_last = ({1'b0, idx_q} + 3'd1) == total;
  assign load    = cmd_valid_i && (!ov_q || pop_i);

  always_comb begin
    if (idx_q < cmd_i.nbytes) begin
      byte_d   = cmd_i.bytes[idx_q];
      status_d = ST_BYTE;
    end else begin
      byte_d   = '0;
      status_d = cmd_i.tail_status;
    end
  end

  assign cmd_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      status_q <= status_d;
      last_q   <= is_last;
    end
  end

  assign empty_o    = !ov_q;
  assign out_byte_o = byte_q;
  assign status_o   = status_q;
  assign last_o     = last_q;

  `ASSERT_IMPLIES(a_status_last, ov_q && status_q != ST_BYTE, last_q,
                  "done or error status not marked last")
  `ASSERT_IMPLIES(a_status_zero, ov_q && status_q != ST_BYTE, byte_q == 8'h00,
                  "status result carries nonzero byte")
  `ASSERT_IMPLIES(a_idx_in_cmd, cmd_valid_i, {1'b0, idx_q} < total,
                  "emit index past end of command")

endmodule

@@ rtl/core/json_string_unescape_unit.sv @@
// Path: a byte's first result reaches the ports through a command queue write and then
//   an output register load (held back while that register still awaits a pop).
// Throughput: one byte per cycle in while full is low, one result per cycle out while
//   pop is high; a \u code gives up to three results, absorbed by the four-entry queue.
// Reset (rst_ni low, asynchronous): phase back to expecting the opening quote, queue
//   and output register emptied.
//
// Structure: the front end runs the string-parsing state machine and turns each
// transferred byte into at most one command (up to three data bytes plus an optional
// done/error status). Bytes that produce nothing (opening quote, backslash, hex
// digits before the last one) never touch the queue. The back end walks the head
// command into an output register, one result per cycle while popped, so a stalled
// consumer only backs up the queue; full rises once four commands are waiting.
module json_string_unescape_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  // byte side
  input  logic             push,
  output logic             full,
  input  logic [7:0]       data_byte_i,
  input  logic             start_of_text_i,
  input  logic             end_of_text_i,
  // result side
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte_o,
  output jsu_pkg::status_e status_o,
  output logic             last_o
);
  import jsu_pkg::*;

  logic fire;
  logic cmd_push, cmd_pop, cmd_valid;
  cmd_t cmd_wr, cmd_rd;

  // a byte transfer happens when push is high and the command queue is not full
  assign fire = push && !full;

  jsu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .data_byte_i     (data_byte_i),
    .start_of_text_i (start_of_text_i),
    .end_of_text_i   (end_of_text_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_wr)
  );

  jsu_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (cmd_push),
    .wr_data_i  (cmd_wr),
    .full_o     (full),
    .rd_i       (cmd_pop),
    .rd_valid_o (cmd_valid),
    .rd_data_o  (cmd_rd)
  );

  // the output register decouples pop from the queue head
  jsu_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
